// ----- rtl/ncr_pkg.sv -----
package ncr_pkg;

  localparam int unsigned TableDepth = 4096;
  localparam int unsigned AddrW = $clog2(TableDepth);
  localparam int unsigned IdxW = AddrW + 1;
  localparam logic [29:0] PrimeMod = 30'd1000000007;
  localparam logic [29:0] FermatExp = 30'd1000000005;
  localparam int unsigned ExpBits = 30;

  typedef struct packed {
    logic [11:0] n_value;
    logic [11:0] r_value;
  } ncr_in_t;

  typedef struct packed {
    logic [29:0] permutations;
    logic [29:0] combinations;
    logic        invalid;
  } ncr_out_t;

  // Multiplier operand sources.
  typedef enum logic [2:0] {
    SRC_ONE,
    SRC_IDX,
    SRC_TBL,
    SRC_ACC,
    SRC_SQ,
    SRC_RES
  } ncr_src_t;

  // Multiplier result destinations.
  typedef enum logic [2:0] {
    DST_NONE,
    DST_TBL,
    DST_ACC,
    DST_SQ,
    DST_RES
  } ncr_dst_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic          load_req;
    logic          rd_en;
    logic [AddrW-1:0] rd_addr;
    logic          latch_rd;
    logic          mul_start;
    ncr_src_t      src_a;
    ncr_src_t      src_b;
    ncr_dst_t      dst;
    logic          init_pow;
    logic          save_rf;
    logic          fill_adv;
  } ncr_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic             mul_done;
    logic [IdxW-1:0]  fill_idx;
    logic [11:0]      n_q;
    logic [11:0]      r_q;
    logic [29:0]      npr;
    logic [29:0]      ncr;
  } ncr_sts_t;

endpackage

// ----- rtl/ncr_modmul.sv -----
module ncr_modmul
  import ncr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [29:0] a,
  input  logic [29:0] b,
  output logic        done,
  output logic [29:0] prod
);

  // Shift-add modular multiply, one bit of b per cycle, MSB first.
  logic [29:0] acc_r, acc_nxt;
  logic [29:0] a_r;
  logic [29:0] b_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [30:0] dbl;
  logic [29:0] dbl_m;
  logic [30:0] add;

  always_comb begin
    dbl = {acc_r, 1'b0};
    dbl_m = (dbl >= {1'b0, PrimeMod}) ? 30'(dbl - {1'b0, PrimeMod}) : dbl[29:0];
    add = {1'b0, dbl_m} + (b_r[29] ? {1'b0, a_r} : 31'd0);
    acc_nxt = (add >= {1'b0, PrimeMod}) ? 30'(add - {1'b0, PrimeMod}) : add[29:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        acc_r  <= '0;
        // Operands are reduced once so the adds stay below twice the prime.
        a_r <= (a >= PrimeMod) ? a - PrimeMod : a;
        b_r <= b;
      end else if (busy_r) begin
        acc_r <= acc_nxt;
        b_r   <= {b_r[28:0], 1'b0};
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd29) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// ----- rtl/ncr_datapath.sv -----
module ncr_datapath
  import ncr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  ncr_in_t  in_item,
  input  ncr_cmd_t cmd,
  output ncr_sts_t sts
);

  logic [29:0] mem [TableDepth];
  logic [29:0] rd_data_r;
  logic [29:0] tbl_r, acc_r, sq_r, res_r;
  logic [29:0] op_a, op_b, prod;
  logic [11:0] n_r, r_r;
  logic [IdxW-1:0] fill_r;
  logic        mul_done;

  // Factorial table memory; entries 0 and 1 are never stored, reads map them to one.
  always_ff @(posedge clk) begin
    if (cmd.dst == DST_TBL && mul_done) begin
      mem[fill_r[AddrW-1:0]] <= prod;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[cmd.rd_addr];
    end
  end

  function automatic logic [29:0] pick(input ncr_src_t s, input logic [29:0] tb,
                                       input logic [29:0] ac, input logic [29:0] sq,
                                       input logic [29:0] rs, input logic [IdxW-1:0] ix);
    logic [29:0] v;
    v = 30'd1;
    case (s)
      SRC_IDX: v = 30'(ix);
      SRC_TBL: v = tb;
      SRC_ACC: v = ac;
      SRC_SQ:  v = sq;
      SRC_RES: v = rs;
      default: v = 30'd1;
    endcase
    return v;
  endfunction

  assign op_a = pick(cmd.src_a, tbl_r, acc_r, sq_r, res_r, fill_r);
  assign op_b = pick(cmd.src_b, tbl_r, acc_r, sq_r, res_r, fill_r);

  ncr_modmul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (op_a),
    .b     (op_b),
    .done  (mul_done),
    .prod  (prod)
  );

  // Working registers and fill pointer. The first exponentiation starts the
  // accumulator at one; the second continues from the first inverse, so the
  // accumulator ends up holding the product of both inverses.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= IdxW'(2);
    end else begin
      if (cmd.load_req) begin
        n_r <= in_item.n_value;
        r_r <= in_item.r_value;
      end
      if (cmd.latch_rd) begin
        tbl_r <= (cmd.rd_addr < AddrW'(2)) ? 30'd1 : rd_data_r;
      end
      if (cmd.init_pow) begin
        sq_r <= tbl_r;
      end
      if (cmd.save_rf) begin
        acc_r <= 30'd1;
        res_r <= tbl_r;
      end
      if (mul_done) begin
        case (cmd.dst)
          DST_TBL: tbl_r <= prod;
          DST_ACC: acc_r <= prod;
          DST_SQ:  sq_r  <= prod;
          DST_RES: res_r <= prod;
          default: ;
        endcase
      end
      if (cmd.fill_adv) begin
        fill_r <= fill_r + IdxW'(1);
      end
    end
  end

  assign sts.mul_done = mul_done;
  assign sts.fill_idx = fill_r;
  assign sts.n_q = n_r;
  assign sts.r_q = r_r;
  assign sts.npr = res_r;
  assign sts.ncr = acc_r;

endmodule

// ----- rtl/ncr_ctrl.sv -----
module ncr_ctrl
  import ncr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  ncr_in_t  in_item,
  output logic     in_ready,
  output ncr_cmd_t cmd,
  input  ncr_sts_t sts,
  output logic     out_valid,
  input  logic     out_ready,
  output ncr_out_t out_item
);

  typedef enum logic [4:0] {
    S_IDLE, S_FILL_RD, S_FILL_LAT, S_FILL_GO, S_FILL_MUL,
    S_RD, S_RD_LAT, S_POW_INIT, S_POW_MGO, S_POW_MUL, S_POW_SGO, S_POW_SQ,
    S_NF_GO, S_NF_MUL, S_PR_GO, S_PR_MUL, S_OUT
  } state_t;

  // Which operand of the formula is in flight.
  typedef enum logic [1:0] {
    P_RF, P_NRF, P_NF
  } phase_t;

  state_t      state_r;
  phase_t      phase_r;
  logic [4:0]  bit_r;
  ncr_out_t    out_r;
  logic        outv_r;
  logic [AddrW-1:0] addr_sel;
  logic [11:0] nmr;

  assign nmr = sts.n_q - sts.r_q;
  assign in_ready = (state_r == S_IDLE) && !outv_r;
  assign out_valid = outv_r;
  assign out_item = out_r;

  always_comb begin
    unique case (phase_r)
      P_RF:    addr_sel = AddrW'(sts.r_q);
      P_NRF:   addr_sel = AddrW'(nmr);
      default: addr_sel = AddrW'(sts.n_q);
    endcase
  end

  // Command decode from state. A multiply is started in a *_GO state and its
  // destination is held in the following wait state until the product lands.
  always_comb begin
    cmd = '0;
    cmd.src_a = SRC_ONE;
    cmd.src_b = SRC_ONE;
    cmd.dst = DST_NONE;
    cmd.load_req = in_valid && in_ready;
    unique case (state_r)
      S_FILL_RD: begin
        cmd.rd_en = 1'b1;
        cmd.rd_addr = AddrW'(sts.fill_idx - IdxW'(1));
      end
      S_FILL_LAT: begin
        cmd.rd_addr = AddrW'(sts.fill_idx - IdxW'(1));
        cmd.latch_rd = 1'b1;
      end
      S_FILL_GO: begin
        cmd.mul_start = 1'b1;
        cmd.src_a = SRC_IDX;
        cmd.src_b = SRC_TBL;
      end
      S_FILL_MUL: begin
        cmd.dst = DST_TBL;
        cmd.fill_adv = sts.mul_done;
      end
      S_RD: begin
        cmd.rd_en = 1'b1;
        cmd.rd_addr = addr_sel;
      end
      S_RD_LAT: begin
        cmd.rd_addr = addr_sel;
        cmd.latch_rd = 1'b1;
      end
      S_POW_INIT: begin
        cmd.init_pow = 1'b1;
        cmd.save_rf = (phase_r == P_RF);
      end
      S_POW_MGO: begin
        cmd.mul_start = FermatExp[bit_r];
        cmd.src_a = SRC_ACC;
        cmd.src_b = SRC_SQ;
      end
      S_POW_MUL: cmd.dst = DST_ACC;
      S_POW_SGO: begin
        cmd.mul_start = 1'b1;
        cmd.src_a = SRC_SQ;
        cmd.src_b = SRC_SQ;
      end
      S_POW_SQ: cmd.dst = DST_SQ;
      S_NF_GO: begin
        cmd.mul_start = 1'b1;
        cmd.src_a = SRC_ACC;
        cmd.src_b = SRC_TBL;
      end
      S_NF_MUL: cmd.dst = DST_ACC;
      S_PR_GO: begin
        cmd.mul_start = 1'b1;
        cmd.src_a = SRC_ACC;
        cmd.src_b = SRC_RES;
      end
      S_PR_MUL: cmd.dst = DST_RES;
      default: ;
    endcase
  end

  // Sequencing: reject r above n or n past the table; otherwise fill the table up
  // to n, invert r! and (n-r)!, then multiply by n! for nCr and by r! for nPr.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= P_RF;
      outv_r <= 1'b0;
      bit_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (outv_r) begin
            if (out_ready) outv_r <= 1'b0;
          end else if (in_valid) begin
            if (in_item.r_value > in_item.n_value ||
                32'(in_item.n_value) >= TableDepth) begin
              out_r <= '{permutations: '0, combinations: '0, invalid: 1'b1};
              outv_r <= 1'b1;
            end else begin
              state_r <= S_FILL_RD;
            end
          end
        end
        S_FILL_RD: begin
          if (sts.fill_idx > IdxW'(sts.n_q)) begin
            phase_r <= P_RF;
            state_r <= S_RD;
          end else begin
            state_r <= S_FILL_LAT;
          end
        end
        S_FILL_LAT:  state_r <= S_FILL_GO;
        S_FILL_GO:   state_r <= S_FILL_MUL;
        S_FILL_MUL:  if (sts.mul_done) state_r <= S_FILL_RD;
        S_RD:        state_r <= S_RD_LAT;
        S_RD_LAT:    state_r <= (phase_r == P_NF) ? S_NF_GO : S_POW_INIT;
        S_POW_INIT: begin
          bit_r <= '0;
          state_r <= S_POW_MGO;
        end
        S_POW_MGO: begin
          // A clear exponent bit skips the multiply and goes straight to the square.
          state_r <= FermatExp[bit_r] ? S_POW_MUL : S_POW_SGO;
        end
        S_POW_MUL:   if (sts.mul_done) state_r <= S_POW_SGO;
        S_POW_SGO:   state_r <= S_POW_SQ;
        S_POW_SQ: begin
          if (sts.mul_done) begin
            if (bit_r == 5'(ExpBits - 1)) begin
              phase_r <= (phase_r == P_RF) ? P_NRF : P_NF;
              state_r <= S_RD;
            end else begin
              bit_r <= bit_r + 5'd1;
              state_r <= S_POW_MGO;
            end
          end
        end
        S_NF_GO:     state_r <= S_NF_MUL;
        S_NF_MUL:    if (sts.mul_done) state_r <= S_PR_GO;
        S_PR_GO:     state_r <= S_PR_MUL;
        S_PR_MUL:    if (sts.mul_done) state_r <= S_OUT;
        S_OUT: begin
          out_r <= '{permutations: sts.npr, combinations: sts.ncr, invalid: 1'b0};
          state_r <= S_IDLE;
          outv_r <= 1'b1;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/modular_ncr_npr_engine.sv -----
// One shared serial modular multiplier does all the work: the factorial table
// entries still missing up to n, then two 30-bit Fermat exponentiations.
// Throughput: one transaction at a time; the next is accepted the cycle after
// the result is taken. A request with r above n is rejected without any
// multiply; its result is valid in the cycle after it is accepted.
// Reset (rst_n, synchronous, active low) clears control and sets the fill index to 2.
module modular_ncr_npr_engine
  import ncr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ncr_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output ncr_out_t out_data
);

  ncr_cmd_t cmd;
  ncr_sts_t sts;

  ncr_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_item(in_data), .in_ready,
    .cmd, .sts, .out_valid, .out_ready, .out_item(out_data)
  );

  ncr_datapath u_dp (
    .clk, .rst_n, .in_item(in_data), .cmd, .sts
  );

  // A rejected request carries zero results.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.invalid |->
      out_data.combinations == '0 && out_data.permutations == '0)
    else $error("invalid result not zero");

  // No new transaction is taken while a result waits.
  a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !out_valid)
    else $error("accept while result pending");

  // A waiting result holds steady until taken.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while waiting");

  // Entries 0 and 1 are fixed, so filling starts at two.
  a_fill_min: assert property (@(posedge clk) disable iff (!rst_n)
    sts.fill_idx >= IdxW'(2))
    else $error("fill index below two");

endmodule

// ----- dv/tb.sv -----
module tb;
  import ncr_pkg::*;

  localparam logic [63:0] Prime = 64'd1000000007;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  ncr_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  ncr_out_t out_data;

  modular_ncr_npr_engine u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Stimulus and expectation stores.
  ncr_in_t  pending_requests[$];
  ncr_out_t expected_answers[$];

  // Predictor state: factorial table and lowest unwritten index.
  logic [29:0] fact_table[TableDepth];
  int unsigned fill_next;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          in_taken;
  int unsigned mismatches;
  int unsigned checked_valid;
  int unsigned checked_invalid;
  bit          failed;

  function automatic logic [29:0] mod_mul(logic [29:0] a, logic [29:0] b);
    logic [63:0] prod;
    prod = 64'(a) * 64'(b);
    return 30'(prod % Prime);
  endfunction

  // Fermat inverse: x^(p-2) mod p by square-and-multiply.
  function automatic logic [29:0] mod_inverse(logic [29:0] x);
    logic [29:0] acc;
    logic [29:0] sq;
    logic [29:0] e;
    acc = 30'd1;
    sq  = x;
    e   = FermatExp;
    while (e != 0) begin
      if (e[0]) acc = mod_mul(acc, sq);
      sq = mod_mul(sq, sq);
      e  = e >> 1;
    end
    return acc;
  endfunction

  function automatic ncr_out_t predict_ncr_npr(ncr_in_t req);
    ncr_out_t res;
    logic [29:0] nf, rf, nrf, ncr;
    int unsigned n, r;
    n = req.n_value;
    r = req.r_value;
    res = '0;
    if (r > n || n >= TableDepth) begin
      res.invalid = 1'b1;
      return res;
    end
    // Extend the table lazily up to n.
    while (fill_next <= n) begin
      fact_table[fill_next] = mod_mul(30'(fill_next), fact_table[fill_next-1]);
      fill_next++;
    end
    nf  = fact_table[n];
    rf  = fact_table[r];
    nrf = fact_table[n-r];
    ncr = mod_mul(mod_mul(nf, mod_inverse(rf)), mod_inverse(nrf));
    res.combinations = ncr;
    res.permutations = mod_mul(ncr, rf);
    return res;
  endfunction

  function automatic ncr_in_t make_req(int unsigned n, int unsigned r);
    ncr_in_t req;
    req.n_value = 12'(n);
    req.r_value = 12'(r);
    return req;
  endfunction

  // Appends one request to the stimulus queue.
  function automatic void add_request(int unsigned n, int unsigned r);
    pending_requests = {pending_requests, make_req(n, r)};
  endfunction

  // Mostly well-formed requests, small n most of the time, some with r above n.
  task automatic queue_random(int unsigned count);
    int unsigned n, r, pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        n = $urandom_range(4094);
        r = $urandom_range(4095, n + 1);
      end else begin
        n = (pick < 70) ? $urandom_range(300) : $urandom_range(4095);
        r = $urandom_range(n);
      end
      add_request(n, r);
    end
  endtask

  // Sampled at the rising edge, where the driven inputs are settled.
  task automatic wait_drained();
    do begin
      @(posedge clk);
    end while (!(pending_requests.size() == 0 && !in_valid &&
                 expected_answers.size() == 0));
  endtask

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Driver: offers the next transaction at the falling edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
      if (!in_valid || in_taken) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= pending_requests.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: records accepted requests and checks each result.
  always @(posedge clk) begin
    ncr_out_t exp_res;
    in_taken = 1'b0;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        expected_answers = {expected_answers, predict_ncr_npr(in_data)};
      end
      if (out_valid && out_ready) begin
        if (expected_answers.size() == 0) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transaction: %p", out_data);
        end else begin
          exp_res = expected_answers.pop_front();
          if (out_data.permutations !== exp_res.permutations ||
              out_data.combinations !== exp_res.combinations ||
              out_data.invalid !== exp_res.invalid) begin
            failed = 1'b1;
            mismatches++;
            if (mismatches <= 10)
              $display({"result mismatch: expected npr=%0d ncr=%0d inv=%0b,",
                        " got npr=%0d ncr=%0d inv=%0b"},
                       exp_res.permutations, exp_res.combinations, exp_res.invalid,
                       out_data.permutations, out_data.combinations, out_data.invalid);
          end
          if (exp_res.invalid) checked_invalid++;
          else checked_valid++;
        end
      end
    end
  end

  // Main sequence.
  initial begin
    in_valid  = 1'b0;
    out_ready = 1'b0;
    in_data   = '0;
    in_taken  = 1'b0;
    rst_n     = 1'b0;
    mismatches = 0;
    checked_valid = 0;
    checked_invalid = 0;
    failed = 1'b0;
    fact_table[0] = 30'd1;
    fact_table[1] = 30'd1;
    fill_next = 2;
    send_idle_pct = 14;
    recv_idle_pct = 69;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: edges of both fields, trivial cases, r above n.
    add_request(0, 0);
    add_request(1, 0);
    add_request(1, 1);
    add_request(0, 1);
    add_request(0, 4095);
    add_request(2, 2);
    add_request(3, 1);
    add_request(5, 3);
    add_request(10, 5);
    add_request(100, 50);
    add_request(4095, 0);
    add_request(4095, 4095);
    add_request(4095, 2048);
    add_request(4095, 2047);
    add_request(4094, 4095);
    add_request(2730, 1365);
    add_request(1365, 2730);
    add_request(4095, 1);
    queue_random(215);
    wait_drained();

    // Second phase: idling swapped, after a full drain of results.
    send_idle_pct = 69;
    recv_idle_pct = 14;
    queue_random(235);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(235);
    wait_drained();
    repeat (2500) @(posedge clk);

    $display("covered %0d served and %0d rejected requests, table filled to index %0d",
             checked_valid, checked_invalid, fill_next - 1);
    $display("mismatches: %0d", mismatches);
    if (!failed && expected_answers.size() == 0) begin
      $display("modular_ncr_npr_engine regression: pass");
    end else begin
      $display("modular_ncr_npr_engine regression: fail");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #(64'd12 * 64'd12_000_000);
    $display("modular_ncr_npr_engine regression: fail");
    $finish;
  end

endmodule
